// ===== sv/lqbm_pkg.sv =====
// shared constants and types for the linked queue buffer manager
`default_nettype none
package lqbm_pkg;

  localparam int POOL_SIZE = 512;
  localparam int IDX_W     = 9;
  localparam int ADDR_W    = $clog2(POOL_SIZE);
  localparam int LINK_W    = $clog2(POOL_SIZE + 1);

  localparam logic [LINK_W-1:0] LINK_NONE = LINK_W'(POOL_SIZE);
  localparam logic [LINK_W-1:0] FREE_TOP  = LINK_W'(POOL_SIZE - 1);
  localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(POOL_SIZE - 1);

  typedef enum logic [1:0] {
    ACT_ALLOC   = 2'd0,
    ACT_RELEASE = 2'd1,
    ACT_APPEND  = 2'd2,
    ACT_TAKE    = 2'd3
  } action_t;

  typedef struct packed {
    logic init;
    logic accept;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic init_last;
    logic out_free;
  } status_t;

endpackage
`default_nettype wire

// ===== sv/lqbm_if.sv =====
// request and result channel interfaces
`default_nettype none
interface lqbm_in_if;
  import lqbm_pkg::*;
  logic             valid;
  logic             ready;
  logic [1:0]       action;
  logic [IDX_W-1:0] entry_index;

  modport source (output valid, action, entry_index, input ready);
  modport sink (input valid, action, entry_index, output ready);
endinterface

interface lqbm_out_if;
  import lqbm_pkg::*;
  logic             valid;
  logic             ready;
  logic [IDX_W-1:0] result_index;
  logic             success;
  logic             queue_empty;
  logic             pool_empty;

  modport source (output valid, result_index, success, queue_empty, pool_empty, input ready);
  modport sink (input valid, result_index, success, queue_empty, pool_empty, output ready);
endinterface
`default_nettype wire

// ===== sv/lqbm_ram.sv =====
// generic single write port ram with registered read
`default_nettype none
module lqbm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
`default_nettype wire

// ===== sv/lqbm_ctrl.sv =====
// controller state machine: link clearing pass, request accept, result finish
`default_nettype none
module lqbm_ctrl
  import lqbm_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    in_valid,
  output logic         in_ready,
  input  wire status_t status,
  output cmd_t         cmd
);

  typedef enum logic [1:0] {
    S_INIT,
    S_IDLE,
    S_EXEC
  } state_t;

  state_t state_r;
  state_t state_nxt;

  always_comb begin
    state_nxt  = state_r;
    cmd        = '0;
    in_ready   = 1'b0;
    unique case (state_r)
      S_INIT: begin
        cmd.init = 1'b1;
        if (status.init_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_nxt  = S_EXEC;
        end
      end
      S_EXEC: begin
        if (status.out_free) begin
          cmd.finish = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: state_nxt = S_INIT;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_INIT;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== sv/lqbm_datapath.sv =====
// datapath: list heads, link memory access and result register
`default_nettype none
module lqbm_datapath
  import lqbm_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire cmd_t             cmd,
  output status_t               status,
  input  wire logic [1:0]       in_action,
  input  wire logic [IDX_W-1:0] in_entry_index,
  input  wire logic             out_ready,
  output logic                  out_valid,
  output logic      [IDX_W-1:0] out_result_index,
  output logic                  out_success,
  output logic                  out_queue_empty,
  output logic                  out_pool_empty
);

  logic [ADDR_W-1:0] init_cnt_r;
  logic [LINK_W-1:0] free_head_r, free_head_nxt;
  logic [LINK_W-1:0] queue_head_r, queue_head_nxt;
  logic [LINK_W-1:0] queue_tail_r, queue_tail_nxt;
  action_t           op_r;
  logic [IDX_W-1:0]  idx_r;
  logic              out_valid_r;
  logic [IDX_W-1:0]  result_r, result_nxt;
  logic              success_r, success_nxt;
  logic              queue_empty_r;
  logic              pool_empty_r;

  logic              wr_en;
  logic [ADDR_W-1:0] wr_addr;
  logic [LINK_W-1:0] wr_data;
  logic              rd_en;
  logic [ADDR_W-1:0] rd_addr;
  logic [LINK_W-1:0] rd_data;

  action_t           in_op;
  logic              in_idx_ok;
  logic              idx_ok;
  logic              free_ok;
  logic              head_ok;
  logic              tail_ok;

  assign in_op     = action_t'(in_action);
  assign in_idx_ok = (LINK_W + IDX_W)'(in_entry_index) < (LINK_W + IDX_W)'(POOL_SIZE);
  assign idx_ok    = (LINK_W + IDX_W)'(idx_r) < (LINK_W + IDX_W)'(POOL_SIZE);
  assign free_ok   = free_head_r < LINK_NONE;
  assign head_ok   = queue_head_r < LINK_NONE;
  assign tail_ok   = queue_tail_r < LINK_NONE;

  assign status.init_last = (init_cnt_r == LAST_ADDR);
  assign status.out_free  = !out_valid_r || out_ready;

  // link memory port control
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = init_cnt_r;
    wr_data = LINK_NONE;
    rd_en   = 1'b0;
    rd_addr = free_head_r[ADDR_W-1:0];
    if (cmd.init) begin
      wr_en = 1'b1;
      if (init_cnt_r != '0) begin
        wr_data = LINK_W'(init_cnt_r - ADDR_W'(1));
      end
    end else if (cmd.accept) begin
      unique case (in_op)
        ACT_ALLOC: begin
          rd_en = 1'b1;
        end
        ACT_RELEASE: begin
          wr_en   = in_idx_ok;
          wr_addr = in_entry_index[ADDR_W-1:0];
          wr_data = free_head_r;
        end
        ACT_APPEND: begin
          wr_en   = in_idx_ok;
          wr_addr = in_entry_index[ADDR_W-1:0];
          wr_data = LINK_NONE;
        end
        ACT_TAKE: begin
          rd_en   = 1'b1;
          rd_addr = queue_head_r[ADDR_W-1:0];
        end
        default: rd_en = 1'b0;
      endcase
    end else if (cmd.finish && op_r == ACT_APPEND) begin
      // link the old tail to the new entry
      wr_en   = idx_ok && head_ok && tail_ok;
      wr_addr = queue_tail_r[ADDR_W-1:0];
      wr_data = LINK_W'(idx_r);
    end
  end

  // list head updates and result
  always_comb begin
    free_head_nxt  = free_head_r;
    queue_head_nxt = queue_head_r;
    queue_tail_nxt = queue_tail_r;
    result_nxt     = '0;
    success_nxt    = 1'b0;
    unique case (op_r)
      ACT_ALLOC: begin
        if (free_ok) begin
          result_nxt    = IDX_W'(free_head_r);
          free_head_nxt = rd_data;
          success_nxt   = 1'b1;
        end
      end
      ACT_RELEASE: begin
        if (idx_ok) begin
          free_head_nxt = LINK_W'(idx_r);
          success_nxt   = 1'b1;
        end
      end
      ACT_APPEND: begin
        if (idx_ok) begin
          if (!(head_ok && tail_ok)) begin
            queue_head_nxt = LINK_W'(idx_r);
          end
          queue_tail_nxt = LINK_W'(idx_r);
          success_nxt    = 1'b1;
        end
      end
      ACT_TAKE: begin
        if (head_ok) begin
          result_nxt     = IDX_W'(queue_head_r);
          queue_head_nxt = rd_data;
          success_nxt    = 1'b1;
        end
      end
      default: success_nxt = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      init_cnt_r   <= '0;
      free_head_r  <= FREE_TOP;
      queue_head_r <= LINK_NONE;
      queue_tail_r <= LINK_NONE;
      out_valid_r  <= 1'b0;
      op_r         <= ACT_ALLOC;
    end else begin
      if (cmd.init && !status.init_last) begin
        init_cnt_r <= init_cnt_r + ADDR_W'(1);
      end
      if (cmd.accept) begin
        op_r <= in_op;
      end
      if (cmd.finish) begin
        free_head_r  <= free_head_nxt;
        queue_head_r <= queue_head_nxt;
        queue_tail_r <= queue_tail_nxt;
        out_valid_r  <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      idx_r <= in_entry_index;
    end
    if (cmd.finish) begin
      result_r      <= result_nxt;
      success_r     <= success_nxt;
      queue_empty_r <= !(queue_head_nxt < LINK_NONE);
      pool_empty_r  <= !(free_head_nxt < LINK_NONE);
    end
  end

  lqbm_ram #(
    .WIDTH (LINK_W),
    .DEPTH (POOL_SIZE)
  ) u_link_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign out_valid        = out_valid_r;
  assign out_result_index = result_r;
  assign out_success      = success_r;
  assign out_queue_empty  = queue_empty_r;
  assign out_pool_empty   = pool_empty_r;

endmodule
`default_nettype wire

// ===== sv/linked_queue_buffer_manager_core.sv =====
// top level of the linked queue buffer manager
`default_nettype none
// Buffer manager over a pool of POOL_SIZE entries sharing one next-link memory:
// a free list run as a stack and a linked FIFO queue. Each request carries an
// action (allocate, release, append, take) and an entry index, and produces
// exactly one result. After reset a clearing pass over all POOL_SIZE entries
// writes the initial free-list links, and no request is taken until it ends.
// Each request then has an accept step, which takes it and issues the link
// memory read or first write, and a finish step, which applies the read data
// or second link write and loads the result register, as the registered read
// and single write port require; finish stalls while the output is occupied.
// A new request is taken while the previous result still waits on the output.
module linked_queue_buffer_manager_core
  import lqbm_pkg::*;
(
  input wire logic clk,
  input wire logic rst_n,
  lqbm_in_if.sink    in_chan,
  lqbm_out_if.source out_chan
);

  cmd_t    cmd;
  status_t status;

  lqbm_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_chan.valid),
    .in_ready (in_chan.ready),
    .status   (status),
    .cmd      (cmd)
  );

  lqbm_datapath u_datapath (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .status           (status),
    .in_action        (in_chan.action),
    .in_entry_index   (in_chan.entry_index),
    .out_ready        (out_chan.ready),
    .out_valid        (out_chan.valid),
    .out_result_index (out_chan.result_index),
    .out_success      (out_chan.success),
    .out_queue_empty  (out_chan.queue_empty),
    .out_pool_empty   (out_chan.pool_empty)
  );

endmodule
`default_nettype wire

// ===== verif/linked_queue_buffer_manager_core_tb.sv =====
// self-checking testbench for the linked queue buffer manager core
`timescale 1ns / 1ps
module linked_queue_buffer_manager_core_tb;
  import lqbm_pkg::*;

  typedef struct packed {
    logic [IDX_W-1:0] result_index;
    logic             success;
    logic             queue_empty;
    logic             pool_empty;
  } result_t;

  typedef enum {MODE_FILL, MODE_DRAIN, MODE_MIX} traffic_mode_t;

  class pool_scoreboard;
    logic [LINK_W-1:0] link_mem [POOL_SIZE];
    logic [LINK_W-1:0] q_head;
    logic [LINK_W-1:0] q_tail;
    logic [LINK_W-1:0] f_head;
    result_t           pending [$];
    int                errors;
    int                checked;

    function new();
      link_mem[0] = LINK_NONE;
      for (int i = 1; i < POOL_SIZE; i++) begin
        link_mem[i] = LINK_W'(i - 1);
      end
      q_head  = LINK_NONE;
      q_tail  = LINK_NONE;
      f_head  = FREE_TOP;
      errors  = 0;
      checked = 0;
    endfunction

    function bit valid_link(logic [LINK_W-1:0] v);
      return v < LINK_W'(POOL_SIZE);
    endfunction

    function result_t note(action_t act, logic [IDX_W-1:0] idx);
      result_t           r;
      logic [LINK_W-1:0] ent;
      r   = '0;
      ent = LINK_W'(idx);
      case (act)
        ACT_ALLOC: begin
          if (valid_link(f_head)) begin
            r.result_index = f_head[IDX_W-1:0];
            f_head = link_mem[f_head[ADDR_W-1:0]];
            r.success = 1'b1;
          end
        end
        ACT_RELEASE: begin
          if (valid_link(ent)) begin
            link_mem[ent[ADDR_W-1:0]] = f_head;
            f_head = ent;
            r.success = 1'b1;
          end
        end
        ACT_APPEND: begin
          if (valid_link(ent)) begin
            link_mem[ent[ADDR_W-1:0]] = LINK_NONE;
            if (valid_link(q_head) && valid_link(q_tail)) begin
              link_mem[q_tail[ADDR_W-1:0]] = ent;
            end else begin
              q_head = ent;
            end
            q_tail = ent;
            r.success = 1'b1;
          end
        end
        default: begin
          if (valid_link(q_head)) begin
            r.result_index = q_head[IDX_W-1:0];
            q_head = link_mem[q_head[ADDR_W-1:0]];
            r.success = 1'b1;
          end
        end
      endcase
      r.queue_empty = !valid_link(q_head);
      r.pool_empty  = !valid_link(f_head);
      pending.push_back(r);
      return r;
    endfunction

    task report(string msg);
      $display("[%0t] mismatch: %s", $realtime, msg);
      errors++;
    endtask

    task check(result_t got);
      result_t exp;
      if (pending.size() == 0) begin
        report($sformatf("result with no request pending (index %0d)", got.result_index));
      end else begin
        exp = pending.pop_front();
        checked++;
        if (got.result_index !== exp.result_index)
          report($sformatf("result_index got %0d exp %0d", got.result_index, exp.result_index));
        if (got.success !== exp.success)
          report($sformatf("success got %0b exp %0b", got.success, exp.success));
        if (got.queue_empty !== exp.queue_empty)
          report($sformatf("queue_empty got %0b exp %0b", got.queue_empty, exp.queue_empty));
        if (got.pool_empty !== exp.pool_empty)
          report($sformatf("pool_empty got %0b exp %0b", got.pool_empty, exp.pool_empty));
      end
    endtask
  endclass

  logic clk;
  logic rst_n;

  lqbm_in_if  in_chan();
  lqbm_out_if out_chan();

  linked_queue_buffer_manager_core uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  pool_scoreboard   sb;
  logic [IDX_W-1:0] held [$];
  int               sender_idle_pct;
  int               recv_stall_pct;
  int               hold_request;
  int               items_sent;
  int               noise_sent;
  int               alloc_fail;
  int               take_fail;
  int               pool_empty_seen;

  initial begin
    clk = 1'b0;
  end

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    #2_000_000;
    $display("*** FAILED ***");
    $finish;
  end

  // result side: check accepted results, then choose next ready
  initial begin
    int hold_left;
    hold_left = 0;
    out_chan.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_chan.valid && out_chan.ready) begin
        sb.check({out_chan.result_index, out_chan.success,
                  out_chan.queue_empty, out_chan.pool_empty});
      end
      if (hold_left > 0) begin
        hold_left--;
        out_chan.ready <= 1'b0;
      end else if (hold_request > 0) begin
        hold_left    = hold_request - 1;
        hold_request = 0;
        out_chan.ready <= 1'b0;
      end else begin
        out_chan.ready <= rst_n && ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  task automatic send_request(input action_t act, input logic [IDX_W-1:0] idx,
                              output result_t pred);
    in_chan.valid       <= 1'b1;
    in_chan.action      <= act;
    in_chan.entry_index <= idx;
    do @(posedge clk); while (!in_chan.ready);
    pred = sb.note(act, idx);
    items_sent++;
    if (!pred.success && act == ACT_ALLOC) alloc_fail++;
    if (!pred.success && act == ACT_TAKE) take_fail++;
    if (pred.pool_empty) pool_empty_seen++;
    if (sender_idle_pct > 0 && $urandom_range(99) < sender_idle_pct) begin
      in_chan.valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < sender_idle_pct) @(posedge clk);
    end
  endtask

  task automatic traffic_step(input traffic_mode_t mode);
    int               r;
    int               k;
    bit               noisy;
    action_t          act;
    logic [IDX_W-1:0] idx;
    result_t          pred;
    r     = $urandom_range(99);
    idx   = IDX_W'($urandom_range(POOL_SIZE - 1));
    noisy = 1'b0;
    case (mode)
      MODE_FILL: begin
        act = (r < 90) ? ACT_ALLOC : (r < 96) ? ACT_APPEND : ACT_TAKE;
      end
      MODE_DRAIN: begin
        act = (r < 15) ? ACT_ALLOC : (r < 25) ? ACT_APPEND :
              (r < 50) ? ACT_TAKE : ACT_RELEASE;
      end
      default: begin
        if (r < 85) begin
          act = (r < 25) ? ACT_ALLOC : (r < 45) ? ACT_APPEND :
                (r < 65) ? ACT_TAKE : ACT_RELEASE;
        end else begin
          // misuse: random action on a random entry
          act   = action_t'($urandom_range(3));
          noisy = 1'b1;
          noise_sent++;
        end
      end
    endcase
    if (!noisy && (act == ACT_APPEND || act == ACT_RELEASE)) begin
      if (held.size() == 0) begin
        act = ACT_ALLOC;
      end else begin
        k   = $urandom_range(held.size() - 1);
        idx = held[k];
        held.delete(k);
      end
    end
    send_request(act, idx, pred);
    if ((act == ACT_ALLOC || act == ACT_TAKE) && pred.success) begin
      held.push_back(pred.result_index);
    end
  endtask

  initial begin
    result_t pred;
    int      n;
    sb              = new();
    sender_idle_pct = 0;
    recv_stall_pct  = 0;
    hold_request    = 0;
    items_sent      = 0;
    noise_sent      = 0;
    alloc_fail      = 0;
    take_fail       = 0;
    pool_empty_seen = 0;
    rst_n               <= 1'b0;
    in_chan.valid       <= 1'b0;
    in_chan.action      <= ACT_ALLOC;
    in_chan.entry_index <= '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // directed: empty queue, double append, last take with stale tail
    send_request(ACT_TAKE,    9'd511, pred);
    send_request(ACT_ALLOC,   9'd0,   pred);
    send_request(ACT_ALLOC,   9'd511, pred);
    send_request(ACT_APPEND,  9'd511, pred);
    send_request(ACT_APPEND,  9'd511, pred);
    send_request(ACT_APPEND,  9'd510, pred);
    send_request(ACT_TAKE,    9'd0,   pred);
    send_request(ACT_TAKE,    9'd0,   pred);
    send_request(ACT_TAKE,    9'd0,   pred);
    send_request(ACT_APPEND,  9'd0,   pred);
    send_request(ACT_TAKE,    9'd511, pred);
    send_request(ACT_TAKE,    9'd0,   pred);
    send_request(ACT_RELEASE, 9'd510, pred);
    send_request(ACT_RELEASE, 9'd511, pred);
    send_request(ACT_ALLOC,   9'd170, pred);
    send_request(ACT_RELEASE, 9'd511, pred);

    // no idling: exhaust the pool, with one long receiver hold-off
    n = 0;
    while (sb.valid_link(sb.f_head) && n < 700) begin
      if (n == 60) hold_request = 300;
      traffic_step(MODE_FILL);
      n++;
    end
    repeat (4) send_request(ACT_ALLOC, IDX_W'($urandom_range(POOL_SIZE - 1)), pred);
    repeat (100) traffic_step(MODE_DRAIN);

    sender_idle_pct = 73;
    recv_stall_pct  = 0;
    repeat (120) traffic_step(MODE_MIX);

    sender_idle_pct = 0;
    recv_stall_pct  = 73;
    repeat (120) traffic_step(MODE_MIX);

    sender_idle_pct = 17;
    recv_stall_pct  = 17;
    repeat (120) traffic_step(MODE_MIX);

    in_chan.valid  <= 1'b0;
    recv_stall_pct = 0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    $display("run covered %0d requests (%0d misuse), %0d results checked",
             items_sent, noise_sent, sb.checked);
    $display("failed allocates %0d, failed takes %0d, results with pool empty %0d",
             alloc_fail, take_fail, pool_empty_seen);
    if (sb.errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
